>>> hw/rtl/lzwd_pkg.sv
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared types and constants of the windowed byte decompressor.
// ----------------------------------------------------------------------------
package lzwd_pkg;

	localparam int HISTORY_DEPTH = 2048;
	localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
	localparam int WRITTEN_W     = HIST_AW + 1;
	localparam int LEN_W         = 27;
	localparam int PADDR_W       = 3;

	localparam logic [LEN_W-1:0]     MAX_IMAGE    = LEN_W'(64 * 1024 * 1024);
	localparam logic [WRITTEN_W-1:0] WRITTEN_SAT  = WRITTEN_W'(HISTORY_DEPTH);
	localparam logic [PADDR_W-1:0]   ADDR_EXP_LEN = 3'd0;

	localparam logic [1:0] STATUS_OK           = 2'd0;
	localparam logic [1:0] STATUS_RUN_LONG     = 2'd1;
	localparam logic [1:0] STATUS_BEFORE_START = 2'd2;
	localparam logic [1:0] STATUS_ZERO_OFFSET  = 2'd3;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_CONTROL,
		PH_LITERAL,
		PH_OFFSET
	} phase_t;

	typedef enum logic {
		EN_ACCEPT,
		EN_COPY
	} engine_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic [1:0] status;
	} res_t;

	typedef struct packed {
		logic               we;
		logic [HIST_AW-1:0] waddr;
		logic [7:0]         wdata;
		logic               re;
		logic [HIST_AW-1:0] raddr;
	} ram_req_t;

endpackage

>>> hw/rtl/lzwd_ram.sv
// ----------------------------------------------------------------------------
// lzwd_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lzwd_ram #(
	parameter int DEPTH = 2048,
	parameter int WIDTH = 8,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/lzwd_out_reg.sv
// ----------------------------------------------------------------------------
// lzwd_out_reg
// Output holding register between the parser and the result channel.
// ----------------------------------------------------------------------------
module lzwd_out_reg
	import lzwd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load_valid,
	input  res_t       load_res,
	output logic       load_ready,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       last,
	output logic [1:0] status
);

	logic valid_q;
	res_t res_q;

	assign load_ready = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_ready) begin
			valid_q <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ready && load_valid) begin
			res_q <= load_res;
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = res_q.data;
	assign last      = res_q.last;
	assign status    = res_q.status;

endmodule

>>> hw/rtl/lzwd_ctrl.sv
// ----------------------------------------------------------------------------
// lzwd_ctrl
// Stream parser and copy sequencer working on the history memory.
// ----------------------------------------------------------------------------
module lzwd_ctrl
	import lzwd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         stream_byte,
	input  logic               first,
	input  logic [LEN_W-1:0]   expected_length,
	input  logic               out_ready,
	output logic               res_valid,
	output res_t               res,
	output ram_req_t           ram_req,
	input  logic [7:0]         ram_rdata
);

	phase_t               phase_q, phase_d;
	engine_t              eng_q, eng_d;
	logic [7:0]           lit_left_q, lit_left_d;
	logic [4:0]           pend_len_q, pend_len_d;
	logic [2:0]           pend_hi_q, pend_hi_d;
	logic [LEN_W-1:0]     rem_q, rem_d;
	logic [WRITTEN_W-1:0] written_q, written_d;
	logic [HIST_AW-1:0]   wp_q, wp_d;
	logic [4:0]           cnt_q, cnt_d;
	logic [HIST_AW-1:0]   off_q, off_d;
	logic                 fwd_q, fwd_d;
	logic [7:0]           last_byte_q;

	logic                 accept;
	phase_t               eff_phase;
	logic [LEN_W-1:0]     eff_rem;
	logic [7:0]           ctl_size;
	logic [4:0]           copy_len;
	logic [HIST_AW-1:0]   offset;
	logic [HIST_AW-1:0]   wp_inc;
	logic [WRITTEN_W-1:0] written_inc;
	logic [7:0]           lit_next;
	logic [LEN_W-1:0]     rem_after_copy;
	logic [7:0]           copy_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			eng_q      <= EN_ACCEPT;
			lit_left_q <= '0;
			pend_len_q <= '0;
			pend_hi_q  <= '0;
			rem_q      <= '0;
			written_q  <= '0;
			wp_q       <= '0;
			cnt_q      <= '0;
			off_q      <= '0;
			fwd_q      <= 1'b0;
		end else begin
			phase_q    <= phase_d;
			eng_q      <= eng_d;
			lit_left_q <= lit_left_d;
			pend_len_q <= pend_len_d;
			pend_hi_q  <= pend_hi_d;
			rem_q      <= rem_d;
			written_q  <= written_d;
			wp_q       <= wp_d;
			cnt_q      <= cnt_d;
			off_q      <= off_d;
			fwd_q      <= fwd_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_req.we) begin
			last_byte_q <= ram_req.wdata;
		end
	end

	always_comb begin
		in_stall       = !(eng_q == EN_ACCEPT && out_ready);
		accept         = in_valid && !in_stall;
		eff_phase      = first ? PH_CONTROL : phase_q;
		eff_rem        = first ? expected_length : rem_q;
		ctl_size       = (stream_byte[6:0] == 7'd0) ? 8'd128 : {1'b0, stream_byte[6:0]};
		copy_len       = ~stream_byte[7:3] + 5'd1;
		offset         = {pend_hi_q, stream_byte};
		wp_inc         = wp_q + 1'b1;
		written_inc    = (written_q == WRITTEN_SAT) ? written_q : written_q + 1'b1;
		lit_next       = lit_left_q - 8'd1;
		rem_after_copy = rem_q - LEN_W'(pend_len_q);
		copy_byte      = fwd_q ? last_byte_q : ram_rdata;

		phase_d    = phase_q;
		eng_d      = eng_q;
		lit_left_d = lit_left_q;
		pend_len_d = pend_len_q;
		pend_hi_d  = pend_hi_q;
		rem_d      = rem_q;
		written_d  = written_q;
		wp_d       = wp_q;
		cnt_d      = cnt_q;
		off_d      = off_q;
		fwd_d      = fwd_q;

		res_valid  = 1'b0;
		res        = '{data: 8'd0, last: 1'b1, status: STATUS_OK};
		ram_req    = '{we: 1'b0, waddr: wp_q, wdata: stream_byte, re: 1'b0,
			raddr: wp_q - offset};

		if (eng_q == EN_COPY) begin
			if (out_ready) begin
				res_valid    = 1'b1;
				res.data     = copy_byte;
				res.last     = (cnt_q == 5'd1) && (rem_q == '0);
				res.status   = STATUS_OK;
				ram_req.we    = 1'b1;
				ram_req.wdata = copy_byte;
				wp_d         = wp_inc;
				written_d    = written_inc;
				cnt_d        = cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					eng_d = EN_ACCEPT;
				end else begin
					ram_req.re    = 1'b1;
					ram_req.raddr = wp_inc - off_q;
					fwd_d         = (off_q == HIST_AW'(1));
				end
			end
		end else if (accept) begin
			if (first) begin
				lit_left_d = '0;
				pend_len_d = '0;
				pend_hi_d  = '0;
				written_d  = '0;
				wp_d       = '0;
				rem_d      = expected_length;
			end
			if (first && expected_length == '0) begin
				phase_d = PH_IDLE;
			end else if (first && expected_length > MAX_IMAGE) begin
				phase_d    = PH_IDLE;
				res_valid  = 1'b1;
				res.status = STATUS_RUN_LONG;
			end else begin
				case (eff_phase)
					PH_CONTROL: begin
						if (!stream_byte[7]) begin
							if (LEN_W'(ctl_size) > eff_rem) begin
								phase_d    = PH_IDLE;
								res_valid  = 1'b1;
								res.status = STATUS_RUN_LONG;
							end else begin
								rem_d      = eff_rem - LEN_W'(ctl_size);
								lit_left_d = ctl_size;
								phase_d    = PH_LITERAL;
							end
						end else begin
							pend_hi_d  = stream_byte[2:0];
							pend_len_d = copy_len;
							phase_d    = PH_OFFSET;
						end
					end
					PH_LITERAL: begin
						ram_req.we = 1'b1;
						wp_d       = wp_inc;
						written_d  = written_inc;
						lit_left_d = lit_next;
						res_valid  = 1'b1;
						res.data   = stream_byte;
						res.last   = (lit_next == 8'd0) && (rem_q == '0);
						res.status = STATUS_OK;
						if (lit_next == 8'd0) begin
							phase_d = (rem_q == '0) ? PH_IDLE : PH_CONTROL;
						end
					end
					PH_OFFSET: begin
						if (WRITTEN_W'(offset) > written_q) begin
							phase_d    = PH_IDLE;
							res_valid  = 1'b1;
							res.status = STATUS_BEFORE_START;
						end else if (LEN_W'(pend_len_q) > rem_q) begin
							phase_d    = PH_IDLE;
							res_valid  = 1'b1;
							res.status = STATUS_RUN_LONG;
						end else if (offset == '0) begin
							phase_d    = PH_IDLE;
							res_valid  = 1'b1;
							res.status = STATUS_ZERO_OFFSET;
						end else begin
							rem_d      = rem_after_copy;
							phase_d    = (rem_after_copy == '0) ? PH_IDLE : PH_CONTROL;
							cnt_d      = pend_len_q;
							off_d      = offset;
							fwd_d      = 1'b0;
							ram_req.re = 1'b1;
							eng_d      = EN_COPY;
						end
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
		end
	end

endmodule

>>> hw/rtl/lz_window_byte_decompressor.sv
// ----------------------------------------------------------------------------
// lz_window_byte_decompressor
// Rebuilds an image from a compressed byte stream with a 2048-byte history.
// ----------------------------------------------------------------------------
// Compressed bytes arrive on the request channel (in_valid, in_stall,
// stream_byte, first); a request with first set starts a new image of
// expected_length bytes; the user must set it over the APB port only while
// idle, as the block does not enforce this. Decompressed bytes leave on the
// result channel (out_valid, out_stall, out_byte, last, status), last marking
// the final byte or an error. A literal or error result enters the output
// register at the edge that accepts its request. A back-reference offset byte
// starts a copy of 1 to 16 bytes and the history read of its first byte; the
// copy then reads the history memory one byte a cycle while the output
// register can take it, with the byte just written forwarded when the offset
// is one. While the receiver stalls and the output register is full, requests
// are stalled and the copy sequencer holds. Reset leaves the parser idle,
// with expected_length at one; bytes before the first request with first
// set are dropped without a result. The history memory needs no clearing.
// ----------------------------------------------------------------------------
module lz_window_byte_decompressor
	import lzwd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         stream_byte,
	input  logic               first,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         out_byte,
	output logic               last,
	output logic [1:0]         status
);

	logic [LEN_W-1:0] exp_len_q;
	logic             out_ready;
	logic             res_valid;
	res_t             res;
	ram_req_t         ram_req;
	logic [7:0]       ram_rdata;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_len_q <= LEN_W'(1);
		end else if (psel && penable && pwrite && paddr == ADDR_EXP_LEN) begin
			exp_len_q <= pwdata[LEN_W-1:0];
		end
	end

	assign prdata = (paddr == ADDR_EXP_LEN) ? {{(32 - LEN_W){1'b0}}, exp_len_q} : 32'd0;

	lzwd_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.stream_byte     (stream_byte),
		.first           (first),
		.expected_length (exp_len_q),
		.out_ready       (out_ready),
		.res_valid       (res_valid),
		.res             (res),
		.ram_req         (ram_req),
		.ram_rdata       (ram_rdata)
	);

	lzwd_ram #(
		.DEPTH (HISTORY_DEPTH),
		.WIDTH (8)
	) u_history (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	lzwd_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (res_valid),
		.load_res   (res),
		.load_ready (out_ready),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.last       (last),
		.status     (status)
	);

endmodule

>>> sim/tb_lz_window_byte_decompressor.sv
// ----------------------------------------------------------------------------
// tb_lz_window_byte_decompressor
// Self-checking testbench for the windowed byte decompressor.
// ----------------------------------------------------------------------------
// Compressed requests are fed with random gaps while the receiver stalls at
// random. A behavioural parser mirrors the history window and queues the
// bytes each accepted request should produce; every result is compared with
// the oldest of them. Directed images cover the edge cases and every error
// status, followed by length extremes, an image that wraps the window,
// a long receiver hold-off and random well-formed images with faults mixed in.
// ----------------------------------------------------------------------------
module tb_lz_window_byte_decompressor;
	import lzwd_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [7:0]         stream_byte = 8'h00;
	logic               first = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [7:0]         out_byte;
	logic               last;
	logic [1:0]         status;

	lz_window_byte_decompressor dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.stream_byte(stream_byte),
		.first      (first),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.last       (last),
		.status     (status)
	);

	always #2 clk = ~clk;

	// Mirror of the parser and the history window.
	logic [7:0]           hist_mirror [HISTORY_DEPTH];
	phase_t               parse_ph = PH_IDLE;
	int                   lit_left = 0;
	int                   copy_len = 0;
	logic [2:0]           off_hi = '0;
	logic [LEN_W-1:0]     bytes_left = '0;
	logic [WRITTEN_W-1:0] bytes_kept = '0;
	logic [HIST_AW-1:0]   wr_ptr = '0;
	logic [LEN_W-1:0]     image_len = LEN_W'(1);
	res_t                 expected_bytes [$];

	int mismatch_count = 0;
	int requests_sent = 0;
	int hold_left = 0;
	bit no_gaps = 1'b0;

	function automatic int min_int(input int a, input int b);
		return (a < b) ? a : b;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		$display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
	endtask

	task automatic expect_byte(input logic [7:0] d, input logic l, input logic [1:0] s);
		res_t r;
		r.data = d;
		r.last = l;
		r.status = s;
		expected_bytes.push_back(r);
	endtask

	task automatic expect_error(input logic [1:0] s);
		parse_ph = PH_IDLE;
		expect_byte(8'h00, 1'b1, s);
	endtask

	task automatic keep_byte(input logic [7:0] b);
		hist_mirror[wr_ptr] = b;
		wr_ptr = wr_ptr + 1'b1;
		if (bytes_kept < WRITTEN_SAT)
			bytes_kept = bytes_kept + 1'b1;
	endtask

	task automatic rebuild_request(input logic [7:0] b, input logic f);
		logic [HIST_AW-1:0] offset;
		logic [7:0]         v;
		int                 size;
		if (f) begin
			lit_left = 0;
			copy_len = 0;
			off_hi = '0;
			bytes_kept = '0;
			wr_ptr = '0;
			bytes_left = image_len;
			if (image_len == '0) begin
				parse_ph = PH_IDLE;
				return;
			end
			if (image_len > MAX_IMAGE) begin
				expect_error(STATUS_RUN_LONG);
				return;
			end
			parse_ph = PH_CONTROL;
		end
		case (parse_ph)
			PH_CONTROL: begin
				if (!b[7]) begin
					size = (b == 8'h00) ? 128 : int'(b);
					if (size > int'(bytes_left)) begin
						expect_error(STATUS_RUN_LONG);
					end else begin
						bytes_left = bytes_left - LEN_W'(size);
						lit_left = size;
						parse_ph = PH_LITERAL;
					end
				end else begin
					off_hi = b[2:0];
					copy_len = 32 - int'(b[7:3]);
					parse_ph = PH_OFFSET;
				end
			end
			PH_LITERAL: begin
				keep_byte(b);
				lit_left--;
				if (lit_left == 0)
					parse_ph = (bytes_left == '0) ? PH_IDLE : PH_CONTROL;
				expect_byte(b, lit_left == 0 && bytes_left == '0, STATUS_OK);
			end
			PH_OFFSET: begin
				offset = {off_hi, b};
				if (offset > bytes_kept) begin
					expect_error(STATUS_BEFORE_START);
				end else if (copy_len > int'(bytes_left)) begin
					expect_error(STATUS_RUN_LONG);
				end else if (offset == '0) begin
					expect_error(STATUS_ZERO_OFFSET);
				end else begin
					bytes_left = bytes_left - LEN_W'(copy_len);
					for (int i = 0; i < copy_len; i++) begin
						v = hist_mirror[HIST_AW'(wr_ptr - offset)];
						keep_byte(v);
						expect_byte(v, i == copy_len - 1 && bytes_left == '0, STATUS_OK);
					end
					parse_ph = (bytes_left == '0) ? PH_IDLE : PH_CONTROL;
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk)
		if (arst_n && in_valid && !in_stall)
			rebuild_request(stream_byte, first);

	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_bytes.size() == 0) begin
				report_mismatch("unexpected result, byte", int'(out_byte), 0);
			end else begin
				want = expected_bytes.pop_front();
				if (out_byte !== want.data)
					report_mismatch("out_byte", int'(out_byte), int'(want.data));
				if (last !== want.last)
					report_mismatch("last", int'(last), int'(want.last));
				if (status !== want.status)
					report_mismatch("status", int'(status), int'(want.status));
			end
		end
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= !no_gaps && ($urandom_range(0, 99) < 29);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic f);
		if (f || parse_ph != PH_IDLE)
			requests_sent++;
		while (!no_gaps && $urandom_range(0, 99) < 29) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		stream_byte <= b;
		first <= f;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_run(input int n, input logic f);
		send_byte((n == 128) ? 8'h00 : 8'(n), f);
		repeat (n)
			send_byte(8'($urandom), 1'b0);
	endtask

	task automatic send_copy(input int len, input int off);
		send_byte({5'(32 - len), 3'(off >> 8)}, 1'b0);
		send_byte(8'(off), 1'b0);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(negedge clk);
		repeat (20)
			@(negedge clk);
	endtask

	task automatic write_length(input logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_EXP_LEN;
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		image_len = v[LEN_W-1:0];
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[LEN_W-1:0] !== image_len)
			report_mismatch("expected_length readback", int'(prdata[LEN_W-1:0]),
				int'(image_len));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic send_fault();
		int len;
		int off;
		case ($urandom_range(0, 3))
			0: begin
				if (bytes_kept < 2047) begin
					send_copy($urandom_range(1, 16), $urandom_range(int'(bytes_kept) + 1, 2047));
				end else begin
					send_copy(1, 0);
				end
			end
			1: begin
				send_copy($urandom_range(1, min_int(16, int'(bytes_left))), 0);
			end
			2: begin
				if (bytes_left < 16) begin
					len = $urandom_range(int'(bytes_left) + 1, 16);
					off = $urandom_range(1, min_int(int'(bytes_kept), 2047));
					send_copy(len, off);
				end else if (bytes_left < 128) begin
					send_run($urandom_range(int'(bytes_left) + 1, 128), 1'b0);
				end else begin
					send_copy(16, 0);
				end
			end
			default: send_run($urandom_range(1, min_int(128, int'(image_len))), 1'b1);
		endcase
	endtask

	task automatic send_image(input int noise_pct);
		bit f;
		f = 1'b1;
		do begin
			if (!f && $urandom_range(0, 99) < noise_pct) begin
				send_fault();
			end else if (!f && bytes_kept > 0 && $urandom_range(0, 1) == 1) begin
				send_copy($urandom_range(1, min_int(16, int'(bytes_left))),
					$urandom_range(1, min_int(int'(bytes_kept), 2047)));
			end else if (f) begin
				send_run($urandom_range(1, min_int(128, int'(image_len))), 1'b1);
			end else begin
				send_run($urandom_range(1, min_int(128, int'(bytes_left))), 1'b0);
			end
			f = 1'b0;
		end while (parse_ph != PH_IDLE);
	endtask

	task automatic test_directed();
		send_byte(8'h55, 1'b0);
		send_byte(8'h01, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		wait_drained();
		write_length(32'd40);
		send_byte(8'h02, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_copy(16, 1);
		send_copy(1, 18);
		send_copy(1, 0);
		send_byte(8'h01, 1'b1);
		send_byte(8'hA5, 1'b0);
		send_copy(16, 2047);
		send_byte(8'h01, 1'b1);
		send_byte(8'h3C, 1'b0);
		send_copy(16, 1);
		send_copy(16, 16);
		send_copy(16, 0);
		wait_drained();
	endtask

	task automatic test_length_settings();
		write_length(32'd0);
		send_byte(8'h11, 1'b1);
		send_byte(8'h22, 1'b0);
		wait_drained();
		write_length(32'd67108865);
		send_byte(8'h01, 1'b1);
		wait_drained();
		write_length(32'hFFFF_FFFF);
		send_byte(8'h01, 1'b1);
		wait_drained();
		write_length(32'd67108864);
		send_run(4, 1'b1);
		send_copy(16, 4);
		wait_drained();
		write_length(32'd1);
		send_byte(8'h00, 1'b1);
		send_byte(8'h01, 1'b1);
		send_byte(8'h80, 1'b0);
		wait_drained();
	endtask

	task automatic test_window_wrap();
		int off;
		write_length(32'd2120);
		no_gaps = 1'b1;
		send_run(16, 1'b1);
		while (parse_ph != PH_IDLE) begin
			if (bytes_kept >= WRITTEN_SAT)
				off = ($urandom_range(0, 3) == 0) ? 2047 : $urandom_range(1, 2047);
			else
				off = $urandom_range(1, min_int(int'(bytes_kept), 2047));
			send_copy(min_int(16, int'(bytes_left)), off);
		end
		no_gaps = 1'b0;
		wait_drained();
	endtask

	task automatic test_backpressure();
		write_length(32'd48);
		hold_left = 150;
		repeat (3)
			send_image(0);
		wait_drained();
	endtask

	task automatic test_random_images();
		int start;
		int phase_no;
		start = requests_sent;
		phase_no = 0;
		while (requests_sent - start < 40) begin
			wait_drained();
			case ($urandom_range(0, 5))
				0: write_length($urandom_range(1, 4));
				1: write_length(32'd128);
				default: write_length($urandom_range(1, 64));
			endcase
			no_gaps = (phase_no == 2);
			repeat ($urandom_range(2, 4)) begin
				send_image(15);
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 3))
						send_byte(8'($urandom), 1'b0);
			end
			phase_no++;
		end
		no_gaps = 1'b0;
		wait_drained();
	endtask

	initial begin
		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_length_settings();
		test_window_wrap();
		test_backpressure();
		test_random_images();
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
